FILE: src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/qfs_pkg.sv
`default_nettype none

package qfs_pkg;

   localparam int SEPARATOR_SLOTS = 4;
   localparam int COUNT_BITS      = 8;
   localparam int CMP_BITS        = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEPARATOR_BYTES = 3'd0,
      CSR_SEPARATOR_COUNT = 3'd1,
      CSR_MAX_FIELDS      = 3'd2,
      CSR_TRIM_MODE       = 3'd3,
      CSR_QUOTE_MODE      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PLAIN  = 3'd1,
      PH_QUOTED = 3'd2,
      PH_ESCAPE = 3'd3,
      PH_AFTERQ = 3'd4
   } phase_type;

   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;

   typedef struct packed {
      logic [31:0] separator_bytes;
      logic [2:0]  separator_count;
      logic [7:0]  max_fields;
      logic        trim_mode;
      logic        quote_mode;
   } cfg_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] char_out;
      logic       char_valid;
      logic       field_end;
      logic       list_end;
   } result_type;

endpackage

`default_nettype wire

FILE: src/qfs_parse.sv
`default_nettype none

module qfs_parse (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  wire  [7:0]           char_in,
   input  wire                  is_term,
   input  wire  qfs_pkg::cfg_type cfg,
   output qfs_pkg::result_type  result
);
   import qfs_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  quote_dq_ff, quote_dq_in;
   logic [COUNT_BITS-1:0] fields_ff, fields_in;
   logic                  final_ff, final_in;

   logic                  sep;
   logic                  last;
   logic                  start_like;
   logic [COUNT_BITS-1:0] fields_inc;
   logic [7:0]            quote_char;
   logic [7:0]            esc_char;
   logic [3:0]            sep_limit;

   always_comb begin
      sep_limit = (cfg.separator_count > 3'(SEPARATOR_SLOTS)) ?
                  4'(SEPARATOR_SLOTS) : {1'b0, cfg.separator_count};
      sep = 1'b0;
      for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
         if (4'(i) < sep_limit) begin
            if (i < 4) begin
               if (cfg.separator_bytes[8*(i%4) +: 8] == char_in) sep = 1'b1;
            end else if (char_in == 8'h00) begin
               sep = 1'b1;
            end
         end
      end
   end

   assign last = (cfg.max_fields != 8'h00) &&
                 (CMP_BITS'(fields_ff) + CMP_BITS'(1) >= CMP_BITS'(cfg.max_fields));
   assign fields_inc = (fields_ff == COUNT_MAX) ? fields_ff : fields_ff + 1'b1;
   assign quote_char = quote_dq_ff ? CH_DQUOTE : CH_SQUOTE;
   assign start_like = (phase_ff != PH_PLAIN) && (phase_ff != PH_QUOTED) &&
                       (phase_ff != PH_ESCAPE) && (phase_ff != PH_AFTERQ);

   always_comb begin
      case (char_in)
         CH_N:    esc_char = CH_LF;
         CH_R:    esc_char = CH_CR;
         CH_T:    esc_char = CH_TAB;
         default: esc_char = char_in;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      quote_dq_in = quote_dq_ff;
      fields_in   = fields_ff;
      final_in    = final_ff;
      result      = '0;
      if (is_term) begin
         result.emit      = 1'b1;
         result.list_end  = 1'b1;
         result.field_end = !((phase_ff == PH_AFTERQ) || (start_like && cfg.trim_mode));
         phase_in    = PH_START;
         quote_dq_in = 1'b0;
         fields_in   = '0;
         final_in    = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_PLAIN: begin
               result.emit = 1'b1;
               if (!final_ff && sep) begin
                  fields_in        = fields_inc;
                  phase_in         = PH_START;
                  result.field_end = 1'b1;
               end else begin
                  result.char_out   = char_in;
                  result.char_valid = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (char_in == CH_BSLASH) begin
                  phase_in = PH_ESCAPE;
               end else if (char_in == quote_char) begin
                  fields_in        = fields_inc;
                  phase_in         = PH_AFTERQ;
                  result.emit      = 1'b1;
                  result.field_end = 1'b1;
               end else begin
                  result.emit       = 1'b1;
                  result.char_out   = char_in;
                  result.char_valid = 1'b1;
               end
            end
            PH_ESCAPE: begin
               phase_in          = PH_QUOTED;
               result.emit       = 1'b1;
               result.char_out   = esc_char;
               result.char_valid = 1'b1;
            end
            PH_AFTERQ: begin
               phase_in = PH_START;
            end
            default: begin
               if (cfg.trim_mode && sep) begin
                  phase_in = phase_ff;
               end else if (!last && cfg.quote_mode &&
                            (char_in == CH_SQUOTE || char_in == CH_DQUOTE)) begin
                  quote_dq_in = (char_in == CH_DQUOTE);
                  final_in    = 1'b0;
                  phase_in    = PH_QUOTED;
               end else if (!last && sep) begin
                  final_in         = 1'b0;
                  fields_in        = fields_inc;
                  phase_in         = PH_START;
                  result.emit      = 1'b1;
                  result.field_end = 1'b1;
               end else begin
                  final_in          = last;
                  phase_in          = PH_PLAIN;
                  result.emit       = 1'b1;
                  result.char_out   = char_in;
                  result.char_valid = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         quote_dq_ff <= 1'b0;
         fields_ff   <= '0;
         final_ff    <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         quote_dq_ff <= quote_dq_in;
         fields_ff   <= fields_in;
         final_ff    <= final_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/quoted_field_splitter.sv
`default_nettype none

// Field splitter for a byte stream. Each req word is one string byte, with
// req_tlast marking the terminator word (its byte is ignored). Each rsp word
// carries a field byte (tuser[0]), an end-of-field mark (tuser[1]) and/or the
// end-of-list mark (tlast); some input words give no rsp word. One word is
// taken every clock while the rsp side is not stalled; a word goes through an
// input register and the parse logic into the result register, and the parse
// state is registered as each word advances. The csr port is to be written by
// the user only while the stream is idle; the block does not enforce this.
// There is no startup sweep after reset.
module quoted_field_splitter (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [7:0] char_in
   input  wire        req_tlast,    // is_terminator
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] char_out
   output logic [1:0] rsp_tuser,    // [0] char_valid, [1] field_end
   output logic       rsp_tlast,    // list_end
   input  wire        csr_we,
   input  wire  [qfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [qfs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import qfs_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_term_ff;
   logic       out_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_cv_ff;
   logic       out_fe_ff;
   logic       out_le_ff;
   logic       advance;
   result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_bytes <= 32'h0;
         cfg_ff.separator_count <= 3'd1;
         cfg_ff.max_fields      <= 8'h00;
         cfg_ff.trim_mode       <= 1'b0;
         cfg_ff.quote_mode      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEPARATOR_BYTES: cfg_ff.separator_bytes <= csr_wdata[31:0];
            CSR_SEPARATOR_COUNT: cfg_ff.separator_count <= csr_wdata[2:0];
            CSR_MAX_FIELDS:      cfg_ff.max_fields      <= csr_wdata[7:0];
            CSR_TRIM_MODE:       cfg_ff.trim_mode       <= csr_wdata[0];
            CSR_QUOTE_MODE:      cfg_ff.quote_mode      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_term_ff <= req_tlast;
      end
   end

   qfs_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .char_in (in_char_ff),
      .is_term (in_term_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_char_ff <= result.char_out;
         out_cv_ff   <= result.char_valid;
         out_fe_ff   <= result.field_end;
         out_le_ff   <= result.list_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = {out_fe_ff, out_cv_ff};
   assign rsp_tlast  = out_le_ff;

endmodule

`default_nettype wire

FILE: src/qfs_checker.sv
`default_nettype none

`include "assert_macros.svh"

module qfs_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire [1:0] rsp_tuser,
   input wire       rsp_tlast
);

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)),
      "stalled rsp word changed")

   `ASSERT_CLK(a_byte_alone, clock, reset,
      (rsp_tvalid && rsp_tuser[0]) |-> (!rsp_tuser[1] && !rsp_tlast),
      "field byte shares a word with a mark")

   `ASSERT_CLK(a_no_byte_zero, clock, reset,
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'h00),
      "mark word carries nonzero data")

   `ASSERT_CLK(a_not_empty, clock, reset,
      rsp_tvalid |-> (rsp_tuser != 2'b00 || rsp_tlast),
      "rsp word carries nothing")

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (.*);

`default_nettype wire

FILE: verif/quoted_field_splitter_tb.sv
`default_nettype none

module quoted_field_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qfs_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       ch_valid;
      logic       fend;
      logic       lend;
   } split_word_t;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_BYTE,
      ROW_CHECK
   } row_kind_t;

   typedef struct packed {
      row_kind_t     kind;
      csr_index_type idx;
      logic [31:0]   val;
      logic          term;
      logic          has_word;
      split_word_t   word;
   } dir_row_t;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   quoted_field_splitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] char_in
      .req_tlast  (req_tlast),    // is_terminator
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] char_out
      .rsp_tuser  (rsp_tuser),    // [0] char_valid, [1] field_end
      .rsp_tlast  (rsp_tlast),    // list_end
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copy
   logic [31:0] cfg_sep   = 32'h0;
   logic [2:0]  cfg_cnt   = 3'd1;
   logic [7:0]  cfg_max   = 8'd0;
   logic        cfg_trim  = 1'b0;
   logic        cfg_quote = 1'b0;

   // per-string parse state
   phase_type   parse_ph  = PH_START;
   logic        quote_dq  = 1'b0;
   logic [7:0]  nfields   = 8'd0;
   logic        final_fld = 1'b0;

   split_word_t split_q[$];
   dir_row_t    dir_tab[$];

   int send_idle     = 0;
   int recv_stall    = 0;
   int bad_words     = 0;
   int words_seen    = 0;
   int bytes_sent    = 0;
   int strings_sent  = 0;
   int settings_used = 0;
   bit dirty         = 1'b0;

   function automatic bit is_sep(input logic [7:0] c);
      int n;
      n = (cfg_cnt > SEPARATOR_SLOTS) ? SEPARATOR_SLOTS : int'(cfg_cnt);
      for (int i = 0; i < n; i++)
         if (cfg_sep[8*i +: 8] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void count_field();
      if (nfields != COUNT_MAX) nfields = nfields + 8'd1;
   endfunction

   // returns 1 when the byte yields a result word
   function automatic bit split_byte(input logic [7:0] c, input logic t,
                                     output split_word_t w);
      bit         last;
      bit         sep;
      logic [7:0] q;
      w = '0;
      if (t) begin
         w.lend = 1'b1;
         w.fend = !(parse_ph == PH_AFTERQ || (parse_ph == PH_START && cfg_trim));
         parse_ph  = PH_START;
         quote_dq  = 1'b0;
         nfields   = 8'd0;
         final_fld = 1'b0;
         return 1'b1;
      end
      case (parse_ph)
         PH_START: begin
            last = (cfg_max != 8'd0) && ({1'b0, nfields} + 9'd1 >= {1'b0, cfg_max});
            sep  = is_sep(c);
            if (cfg_trim && sep) return 1'b0;
            if (!last && cfg_quote && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
               quote_dq  = (c == CH_DQUOTE);
               final_fld = 1'b0;
               parse_ph  = PH_QUOTED;
               return 1'b0;
            end
            final_fld = last;
            if (!last && sep) begin
               count_field();
               w.fend = 1'b1;
               return 1'b1;
            end
            parse_ph   = PH_PLAIN;
            w.ch       = c;
            w.ch_valid = 1'b1;
            return 1'b1;
         end
         PH_PLAIN: begin
            if (!final_fld && is_sep(c)) begin
               count_field();
               parse_ph = PH_START;
               w.fend   = 1'b1;
            end else begin
               w.ch       = c;
               w.ch_valid = 1'b1;
            end
            return 1'b1;
         end
         PH_QUOTED: begin
            q = quote_dq ? CH_DQUOTE : CH_SQUOTE;
            if (c == CH_BSLASH) begin
               parse_ph = PH_ESCAPE;
               return 1'b0;
            end
            if (c == q) begin
               count_field();
               parse_ph = PH_AFTERQ;
               w.fend   = 1'b1;
               return 1'b1;
            end
            w.ch       = c;
            w.ch_valid = 1'b1;
            return 1'b1;
         end
         PH_ESCAPE: begin
            if (c == CH_N)      w.ch = CH_LF;
            else if (c == CH_R) w.ch = CH_CR;
            else if (c == CH_T) w.ch = CH_TAB;
            else                w.ch = c;
            w.ch_valid = 1'b1;
            parse_ph   = PH_QUOTED;
            return 1'b1;
         end
         default: begin
            // byte after a closing quote is dropped
            parse_ph = PH_START;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic dir_row_t csr_row(input csr_index_type i, input logic [31:0] v);
      dir_row_t r;
      r      = '0;
      r.kind = ROW_CSR;
      r.idx  = i;
      r.val  = v;
      return r;
   endfunction

   function automatic dir_row_t byte_row(input logic [7:0] c, input logic t);
      dir_row_t r;
      r      = '0;
      r.kind = ROW_BYTE;
      r.val  = {24'h0, c};
      r.term = t;
      return r;
   endfunction

   function automatic dir_row_t check_row(input logic [7:0] c, input logic t,
                                          input logic has, input split_word_t w);
      dir_row_t r;
      r          = byte_row(c, t);
      r.kind     = ROW_CHECK;
      r.has_word = has;
      r.word     = w;
      return r;
   endfunction

   function automatic logic [7:0] sep_byte();
      int n;
      n = (cfg_cnt > SEPARATOR_SLOTS) ? SEPARATOR_SLOTS : int'(cfg_cnt);
      if (n == 0) return 8'($urandom_range(255));
      return cfg_sep[8*$urandom_range(n-1) +: 8];
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0, 1: return sep_byte();
         2: return CH_SQUOTE;
         3: return CH_DQUOTE;
         4: return CH_BSLASH;
         5: begin
            case ($urandom_range(2))
               0: return CH_N;
               1: return CH_R;
               default: return CH_T;
            endcase
         end
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic note_bad(input string what, input split_word_t want,
                           input split_word_t got);
      bad_words++;
      if (bad_words <= 10)
         $display("%0t %s: expected ch=%02h v=%0b fe=%0b le=%0b, %s",
                  $time, what, want.ch, want.ch_valid, want.fend, want.lend,
                  $sformatf("got ch=%02h v=%0b fe=%0b le=%0b",
                            got.ch, got.ch_valid, got.fend, got.lend));
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 70; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 70; end
         default: begin send_idle = 19; recv_stall = 19; end
      endcase
   endtask

   task automatic drive_byte(input logic [7:0] c, input logic t);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= t;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (t) strings_sent++;
      dirty = 1'b1;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic t);
      split_word_t w;
      drive_byte(c, t);
      if (split_byte(c, t, w)) split_q.push_back(w);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (split_q.size() != 0);
   endtask

   // bytes that give no word may still be in the pipe
   task automatic settle();
      drain();
      repeat (6) @(posedge clock);
      dirty = 1'b0;
   endtask

   task automatic write_csr(input csr_index_type i, input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      case (i)
         CSR_SEPARATOR_BYTES: cfg_sep   = v;
         CSR_SEPARATOR_COUNT: cfg_cnt   = v[2:0];
         CSR_MAX_FIELDS:      cfg_max   = v[7:0];
         CSR_TRIM_MODE:       cfg_trim  = v[0];
         CSR_QUOTE_MODE:      cfg_quote = v[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] sep, input logic [2:0] cnt,
                             input logic [7:0] lim, input logic trim, input logic quote);
      if (dirty) settle();
      write_csr(CSR_SEPARATOR_BYTES, sep);
      write_csr(CSR_SEPARATOR_COUNT, {29'h0, cnt});
      write_csr(CSR_MAX_FIELDS, {24'h0, lim});
      write_csr(CSR_TRIM_MODE, {31'h0, trim});
      write_csr(CSR_QUOTE_MODE, {31'h0, quote});
      settings_used++;
   endtask

   task automatic send_string();
      int         nfld;
      int         len;
      logic [7:0] q;
      logic [7:0] b;
      if ($urandom_range(4) == 0) begin
         // noise
         len = $urandom_range(1, 12);
         for (int k = 0; k < len; k++) send_byte(pick_byte(), 1'b0);
      end else begin
         nfld = $urandom_range(0, 5);
         if ($urandom_range(3) == 0) send_byte(sep_byte(), 1'b0);
         for (int k = 0; k < nfld; k++) begin
            len = $urandom_range(0, 6);
            if (cfg_quote && $urandom_range(1)) begin
               q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
               send_byte(q, 1'b0);
               for (int j = 0; j < len; j++) begin
                  if ($urandom_range(4) == 0) begin
                     send_byte(CH_BSLASH, 1'b0);
                     send_byte(pick_byte(), 1'b0);
                  end else begin
                     do b = pick_byte(); while (b == q || b == CH_BSLASH);
                     send_byte(b, 1'b0);
                  end
               end
               // now and then left open
               if ($urandom_range(9) != 0) send_byte(q, 1'b0);
            end else begin
               for (int j = 0; j < len; j++) begin
                  b = pick_byte();
                  while (is_sep(b)) b = 8'($urandom_range(255));
                  send_byte(b, 1'b0);
               end
            end
            if (k + 1 < nfld || $urandom_range(3) == 0) send_byte(sep_byte(), 1'b0);
            if ($urandom_range(5) == 0) send_byte(sep_byte(), 1'b0);
         end
      end
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin : watch_rsp
      split_word_t got;
      split_word_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast};
         words_seen++;
         if (split_q.size() == 0) begin
            note_bad("unexpected word", '0, got);
         end else begin
            want = split_q.pop_front();
            if (got.ch !== want.ch || got.ch_valid !== want.ch_valid ||
                got.fend !== want.fend || got.lend !== want.lend)
               note_bad("mismatch", want, got);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : main
      split_word_t w;
      bit          has;
      bit          held;
      int          start;
      logic [7:0]  lim;

      // reset settings: separator is byte zero, no trim, no quotes
      dir_tab.push_back(check_row(8'hFF, 1'b0, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0}));
      dir_tab.push_back(check_row(8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}));
      dir_tab.push_back(check_row(8'h00, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}));
      dir_tab.push_back(check_row(8'h41, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}));
      // comma and space, trim, quotes
      dir_tab.push_back(csr_row(CSR_SEPARATOR_BYTES, 32'h0000_202C));
      dir_tab.push_back(csr_row(CSR_SEPARATOR_COUNT, 32'd2));
      dir_tab.push_back(csr_row(CSR_TRIM_MODE, 32'd1));
      dir_tab.push_back(csr_row(CSR_QUOTE_MODE, 32'd1));
      dir_tab.push_back(check_row(",", 1'b0, 1'b0, '0));
      dir_tab.push_back(byte_row(" ", 1'b0));
      dir_tab.push_back(byte_row(CH_DQUOTE, 1'b0));
      dir_tab.push_back(byte_row(CH_BSLASH, 1'b0));
      dir_tab.push_back(check_row(CH_N, 1'b0, 1'b1, {CH_LF, 1'b1, 1'b0, 1'b0}));
      dir_tab.push_back(byte_row(CH_BSLASH, 1'b0));
      dir_tab.push_back(check_row(CH_R, 1'b0, 1'b1, {CH_CR, 1'b1, 1'b0, 1'b0}));
      dir_tab.push_back(byte_row(CH_BSLASH, 1'b0));
      dir_tab.push_back(check_row(CH_T, 1'b0, 1'b1, {CH_TAB, 1'b1, 1'b0, 1'b0}));
      dir_tab.push_back(byte_row(CH_BSLASH, 1'b0));
      dir_tab.push_back(byte_row(CH_DQUOTE, 1'b0));
      dir_tab.push_back(byte_row(CH_SQUOTE, 1'b0));
      dir_tab.push_back(check_row(CH_DQUOTE, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0}));
      dir_tab.push_back(check_row("x", 1'b0, 1'b0, '0));
      dir_tab.push_back(byte_row(CH_SQUOTE, 1'b0));
      dir_tab.push_back(byte_row(CH_SQUOTE, 1'b0));
      dir_tab.push_back(check_row(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1}));
      dir_tab.push_back(check_row(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1}));
      dir_tab.push_back(byte_row(CH_SQUOTE, 1'b0));
      dir_tab.push_back(byte_row(CH_BSLASH, 1'b0));
      dir_tab.push_back(check_row(8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}));
      // field limit of two: second field verbatim
      dir_tab.push_back(csr_row(CSR_MAX_FIELDS, 32'd2));
      dir_tab.push_back(byte_row("a", 1'b0));
      dir_tab.push_back(byte_row(",", 1'b0));
      dir_tab.push_back(byte_row(" ", 1'b0));
      dir_tab.push_back(byte_row(CH_DQUOTE, 1'b0));
      dir_tab.push_back(byte_row(",", 1'b0));
      dir_tab.push_back(byte_row(8'h00, 1'b1));
      // count above slot number, all slots 0xFF
      dir_tab.push_back(csr_row(CSR_SEPARATOR_BYTES, 32'hFFFF_FFFF));
      dir_tab.push_back(csr_row(CSR_SEPARATOR_COUNT, 32'd7));
      dir_tab.push_back(csr_row(CSR_MAX_FIELDS, 32'd0));
      dir_tab.push_back(csr_row(CSR_TRIM_MODE, 32'd0));
      dir_tab.push_back(csr_row(CSR_QUOTE_MODE, 32'd0));
      dir_tab.push_back(byte_row(8'h00, 1'b0));
      dir_tab.push_back(byte_row(8'hFF, 1'b0));
      dir_tab.push_back(byte_row(8'h00, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(0);
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            if (dirty) settle();
            write_csr(dir_tab[i].idx, dir_tab[i].val);
         end else begin
            drive_byte(dir_tab[i].val[7:0], dir_tab[i].term);
            has = split_byte(dir_tab[i].val[7:0], dir_tab[i].term, w);
            if (dir_tab[i].kind == ROW_CHECK) begin
               has = dir_tab[i].has_word;
               w   = dir_tab[i].word;
            end
            if (has) split_q.push_back(w);
         end
      end
      settings_used++;

      for (int p = 0; p < 10; p++) begin
         lim = $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 6));
         case (p)
            0: set_config(32'hFFFF_FFFF, 3'd7, 8'd255, 1'b1, 1'b1);
            1: set_config(32'h0, 3'd0, 8'd0, 1'b0, 1'b0);
            2: set_config($urandom, 3'($urandom_range(1, 4)), 8'd1,
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            default: set_config($urandom, 3'($urandom_range(7)), lim,
                                1'($urandom_range(1)), 1'($urandom_range(1)));
         endcase
         set_idle(p % 4);
         start = bytes_sent;
         held  = 1'b0;
         while (bytes_sent - start < 16) begin
            if (p == 5 && !held && bytes_sent - start >= 8) begin
               // hold off mid-stream until all words are back
               drain();
               held = 1'b1;
            end
            send_string();
         end
      end

      // long string: reach the field limit of 255
      set_config($urandom, 3'd1, 8'd255, 1'b0, 1'($urandom_range(1)));
      set_idle(3);
      for (int n = 0; n < 260; n++) send_byte(sep_byte(), 1'b0);
      for (int n = 0; n < 8; n++) send_byte(pick_byte(), 1'b0);
      send_byte(8'h00, 1'b1);

      req_tvalid <= 1'b0;
      for (int n = 0; n < 20000 && split_q.size() != 0; n++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (split_q.size() != 0) begin
         $display("%0d expected words never arrived", split_q.size());
         bad_words += split_q.size();
      end

      $display("%0d request words in %0d strings under %0d register settings",
               bytes_sent, strings_sent, settings_used);
      $display("%0d result words compared, %0d mismatches", words_seen, bad_words);
      if (bad_words == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/qfs_pkg.sv
src/qfs_parse.sv
src/quoted_field_splitter.sv
src/qfs_checker.sv
verif/quoted_field_splitter_tb.sv
